### hw/rtl/sdpr_pkg.sv
package sdpr_pkg;

    localparam int unsigned STEP_W  = 10;
    localparam int unsigned DELAY_W = 8;
    localparam int unsigned COIL_W  = 6;
    localparam int unsigned BIN_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUARTER_STEPS  = 3'd0,
        REG_HALF_STEPS     = 3'd1,
        REG_INITIAL_STEPS  = 3'd2,
        REG_DECEL_STEPS    = 3'd3,
        REG_START_DELAY_MS = 3'd4,
        REG_MIN_DELAY_MS   = 3'd5
    } cfg_reg_t;

    // bin difference codes (target - current, mod 4)
    localparam logic [BIN_W-1:0] DIFF_NONE = 2'd0;
    localparam logic [BIN_W-1:0] DIFF_CW   = 2'd1;
    localparam logic [BIN_W-1:0] DIFF_HALF = 2'd2;
    localparam logic [BIN_W-1:0] DIFF_CCW  = 2'd3;

    localparam logic [BIN_W-1:0] RESET_BIN = 2'd2;

    localparam logic [STEP_W-1:0]  RESET_QUARTER_STEPS  = 10'd50;
    localparam logic [STEP_W-1:0]  RESET_HALF_STEPS     = 10'd100;
    localparam logic [STEP_W-1:0]  RESET_INITIAL_STEPS  = 10'd10;
    localparam logic [STEP_W-1:0]  RESET_DECEL_STEPS    = 10'd19;
    localparam logic [DELAY_W-1:0] RESET_START_DELAY_MS = 8'd20;
    localparam logic [DELAY_W-1:0] RESET_MIN_DELAY_MS   = 8'd1;

    localparam logic [DELAY_W-1:0] DELAY_MAX = 8'd255;

    // coil drive pattern for each phase
    localparam logic [COIL_W-1:0] COIL_TABLE [4] = '{
        6'b110000, 6'b000110, 6'b101000, 6'b000101
    };

    // delay plan for one step
    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] ms;
        logic               post_inc;
    } step_plan_t;

endpackage

### hw/rtl/stepper_dish_positioner_ramp.sv
// Stepper positioner for a four-bin dish with a trapezoidal speed ramp. Each input item is
// either a one millisecond tick (action 0) or a move command (action 1) naming a target bin;
// every item gives exactly one result item carrying the coil pattern last driven, the busy
// flag, the bin the dish is at or heading to, and move_done on the item that ends a move.
// A command while busy is dropped. Quarter turns go the short way, half turns clockwise.
// The ramp holds start_delay_ms for the first initial_steps steps, then speeds up by one ms
// per step down to min_delay_ms, and slows down by one ms per step (to 255) over the last
// decel_steps steps. Rate: one item per clock cycle; in_ready is high whenever the result
// register is empty or its item is taken in the same cycle. That figure is set by the
// combinational update of the step state (one 11-bit add and compare for the ramp region).
// Configuration is a write port with cfg_ready always high; indexes 6 and 7 are ignored.
module stepper_dish_positioner_ramp (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [sdpr_pkg::BIN_W-1:0]          target_bin,
    // result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sdpr_pkg::COIL_W-1:0]         coil_pattern,
    output logic                                busy_res,
    output logic [sdpr_pkg::BIN_W-1:0]          current_bin,
    output logic                                move_done,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic [sdpr_pkg::STEP_W-1:0]  quarter_steps_reg;
    logic [sdpr_pkg::STEP_W-1:0]  half_steps_reg;
    logic [sdpr_pkg::STEP_W-1:0]  initial_steps_reg;
    logic [sdpr_pkg::STEP_W-1:0]  decel_steps_reg;
    logic [sdpr_pkg::DELAY_W-1:0] start_delay_reg;
    logic [sdpr_pkg::DELAY_W-1:0] min_delay_reg;

    // motion state
    logic [sdpr_pkg::BIN_W-1:0]   bin_reg,        bin_next;
    logic [1:0]                   phase_reg,      phase_next;
    logic [sdpr_pkg::STEP_W-1:0]  step_idx_reg,   step_idx_next;
    logic [sdpr_pkg::STEP_W-1:0]  step_total_reg, step_total_next;
    logic [sdpr_pkg::DELAY_W-1:0] delay_reg,      delay_next;
    logic [sdpr_pkg::DELAY_W-1:0] ms_left_reg,    ms_left_next;
    logic                         moving_reg,     moving_next;
    logic                         cw_reg,         cw_next;
    logic                         post_inc_reg,   post_inc_next;
    logic [sdpr_pkg::COIL_W-1:0]  coil_reg,       coil_next;

    // result register
    logic                         out_valid_reg;
    logic                         done_reg,       done_next;

    logic                         in_fire;

    // ramp decision for the step about to start
    function automatic sdpr_pkg::step_plan_t plan_step(
        input logic [sdpr_pkg::STEP_W-1:0]  idx,
        input logic [sdpr_pkg::DELAY_W-1:0] dly,
        input logic [sdpr_pkg::STEP_W-1:0]  total,
        input logic [sdpr_pkg::STEP_W-1:0]  init_steps,
        input logic [sdpr_pkg::STEP_W-1:0]  dec_steps,
        input logic [sdpr_pkg::DELAY_W-1:0] min_dly
    );
        sdpr_pkg::step_plan_t       plan;
        logic [sdpr_pkg::STEP_W:0]  accel_end;
        plan.delay    = dly;
        plan.post_inc = 1'b0;
        accel_end     = {1'b0, idx} + {1'b0, dec_steps};
        if (idx < init_steps)
        begin
            // hold the start delay
            plan.delay = dly;
        end
        else if (accel_end < {1'b0, total})
        begin
            // accelerate: shorten before use, down to the floor
            if (dly > min_dly)
            begin
                plan.delay = dly - 8'd1;
            end
        end
        else
        begin
            // decelerate: lengthen after use
            plan.post_inc = 1'b1;
        end
        // a zero delay still lasts one tick
        plan.ms = (plan.delay == '0) ? 8'd1 : plan.delay;
        return plan;
    endfunction

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // state update for one item
    always_comb
    begin
        sdpr_pkg::step_plan_t        plan;
        logic [sdpr_pkg::BIN_W-1:0]  diff;
        logic [sdpr_pkg::STEP_W-1:0] n;
        logic [sdpr_pkg::DELAY_W-1:0] ms_dec;

        bin_next        = bin_reg;
        phase_next      = phase_reg;
        step_idx_next   = step_idx_reg;
        step_total_next = step_total_reg;
        delay_next      = delay_reg;
        ms_left_next    = ms_left_reg;
        moving_next     = moving_reg;
        cw_next         = cw_reg;
        post_inc_next   = post_inc_reg;
        coil_next       = coil_reg;
        done_next       = 1'b0;
        plan            = '0;
        diff            = target_bin - bin_reg;
        n               = '0;
        ms_dec          = (ms_left_reg != '0) ? ms_left_reg - 8'd1 : ms_left_reg;

        if (action)
        begin
            // move command, dropped while busy
            if (!moving_reg)
            begin
                bin_next = target_bin;
                case (diff)
                    sdpr_pkg::DIFF_CW:
                    begin
                        n       = quarter_steps_reg;
                        cw_next = 1'b1;
                    end
                    sdpr_pkg::DIFF_CCW:
                    begin
                        n       = quarter_steps_reg;
                        cw_next = 1'b0;
                    end
                    sdpr_pkg::DIFF_HALF:
                    begin
                        n       = half_steps_reg;
                        cw_next = 1'b1;
                    end
                    default:
                    begin
                        n = '0;
                    end
                endcase
                if (diff != sdpr_pkg::DIFF_NONE)
                begin
                    step_total_next = n;
                    step_idx_next   = '0;
                    delay_next      = start_delay_reg;
                    if (n == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        moving_next   = 1'b1;
                        plan          = plan_step('0, start_delay_reg, n, initial_steps_reg,
                                                  decel_steps_reg, min_delay_reg);
                        delay_next    = plan.delay;
                        ms_left_next  = plan.ms;
                        post_inc_next = plan.post_inc;
                        coil_next     = sdpr_pkg::COIL_TABLE[phase_reg];
                    end
                end
            end
        end
        else if (moving_reg)
        begin
            // millisecond tick during a move
            ms_left_next = ms_dec;
            if (ms_dec == '0)
            begin
                if (post_inc_reg && delay_reg < sdpr_pkg::DELAY_MAX)
                begin
                    delay_next = delay_reg + 8'd1;
                end
                phase_next    = cw_reg ? phase_reg + 2'd1 : phase_reg - 2'd1;
                step_idx_next = step_idx_reg + 10'd1;
                if (step_idx_next >= step_total_reg)
                begin
                    moving_next = 1'b0;
                    done_next   = 1'b1;
                end
                else
                begin
                    plan          = plan_step(step_idx_next, delay_next, step_total_reg,
                                              initial_steps_reg, decel_steps_reg,
                                              min_delay_reg);
                    delay_next    = plan.delay;
                    ms_left_next  = plan.ms;
                    post_inc_next = plan.post_inc;
                    coil_next     = sdpr_pkg::COIL_TABLE[phase_next];
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_steps_reg <= sdpr_pkg::RESET_QUARTER_STEPS;
            half_steps_reg    <= sdpr_pkg::RESET_HALF_STEPS;
            initial_steps_reg <= sdpr_pkg::RESET_INITIAL_STEPS;
            decel_steps_reg   <= sdpr_pkg::RESET_DECEL_STEPS;
            start_delay_reg   <= sdpr_pkg::RESET_START_DELAY_MS;
            min_delay_reg     <= sdpr_pkg::RESET_MIN_DELAY_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sdpr_pkg::REG_QUARTER_STEPS:  quarter_steps_reg <= cfg_data;
                sdpr_pkg::REG_HALF_STEPS:     half_steps_reg    <= cfg_data;
                sdpr_pkg::REG_INITIAL_STEPS:  initial_steps_reg <= cfg_data;
                sdpr_pkg::REG_DECEL_STEPS:    decel_steps_reg   <= cfg_data;
                sdpr_pkg::REG_START_DELAY_MS: start_delay_reg   <= cfg_data[7:0];
                sdpr_pkg::REG_MIN_DELAY_MS:   min_delay_reg     <= cfg_data[7:0];
                default:                      ;
            endcase
        end
    end

    // motion state, updated once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg        <= sdpr_pkg::RESET_BIN;
            phase_reg      <= '0;
            step_idx_reg   <= '0;
            step_total_reg <= '0;
            delay_reg      <= '0;
            ms_left_reg    <= '0;
            moving_reg     <= 1'b0;
            cw_reg         <= 1'b1;
            post_inc_reg   <= 1'b0;
            coil_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else if (in_fire)
        begin
            bin_reg        <= bin_next;
            phase_reg      <= phase_next;
            step_idx_reg   <= step_idx_next;
            step_total_reg <= step_total_next;
            delay_reg      <= delay_next;
            ms_left_reg    <= ms_left_next;
            moving_reg     <= moving_next;
            cw_reg         <= cw_next;
            post_inc_reg   <= post_inc_next;
            coil_reg       <= coil_next;
            done_reg       <= done_next;
        end
    end

    // result valid; the state holds while a result waits since in_ready is low
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coil_pattern = coil_reg;
    assign busy_res     = moving_reg;
    assign current_bin  = bin_reg;
    assign move_done    = done_reg;

endmodule
